// ===== design/gbp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbp_pkg: shared types and constants of the grid broad-phase collision block
// Command codes, the stored box record, the control/status bundles between
// the controller and the datapath, and the grid cell function.
// ----------------------------------------------------------------------------
package gbp_pkg;

	localparam int CoordW = 20;
	localparam int IdW    = 16;
	localparam int CellW  = 13;
	localparam int SlotW  = 6;
	localparam int CmdW   = 2;
	localparam int CountW = 6;

	localparam logic [CmdW-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CmdW-1:0] CMD_LOAD  = 2'd1;
	localparam logic [CmdW-1:0] CMD_QUERY = 2'd2;

	// Most pairs reported for one query.
	localparam logic [CountW-1:0] RESULT_CAP = 6'd63;

	// Division by the cell size 160 is a shift by 5 followed by a
	// multiplication with the reciprocal of 5 (52429 / 2^18), exact for
	// every 15-bit quotient.
	localparam int              CellShift  = 5;
	localparam logic [15:0]     RECIP_FIVE = 16'd52429;
	localparam int              RecipShift = 18;

	typedef struct packed {
		logic signed [CoordW-1:0] left;
		logic signed [CoordW-1:0] right;
		logic signed [CoordW-1:0] top;
		logic signed [CoordW-1:0] bottom;
		logic                     live;
		logic [IdW-1:0]           owner;
		logic [IdW-1:0]           tag;
		logic signed [CellW-1:0]  cx;
		logic signed [CellW-1:0]  cy;
	} box_entry_t;

	typedef struct packed {
		logic capture;    // latch the accepted input word
		logic clear;      // empty the store
		logic load_wr;    // append the captured box
		logic q_read;     // read the queried slot
		logic q_check;    // latch the queried box and arm the scan
		logic scan_run;   // advance the neighbor scan
		logic emit_final; // send the closing result
	} dp_cmd_t;

	typedef struct packed {
		logic q_ok;       // queried slot exists and is live
		logic scan_done;  // every pass issued and the compare stage empty
		logic out_free;   // output register can take a word this cycle
	} dp_stat_t;

	// Grid cell of a coordinate: value / 160, truncated toward zero.
	function automatic logic signed [CellW-1:0] cell_of(input logic signed [CoordW-1:0] v);
		logic [CoordW-1:0]   mag;
		logic [14:0]         m;
		logic [30:0]         prod;
		logic [CellW-1:0]    q;
		mag  = v[CoordW-1] ? (~v + 1'b1) : v;
		m    = mag[CoordW-1:CellShift];
		prod = 31'(m) * 31'(RECIP_FIVE);
		q    = prod[RecipShift+CellW-1:RecipShift];
		cell_of = v[CoordW-1] ? signed'(~q + 1'b1) : signed'(q);
	endfunction

endpackage

// ===== design/gbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbp_ctrl: command sequencer
// Decodes each accepted word and steps the datapath through load, query
// lookup, neighbor scan and the closing result.
// ----------------------------------------------------------------------------
module gbp_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [gbp_pkg::CmdW-1:0]    command,
	input  gbp_pkg::dp_stat_t           stat,
	output gbp_pkg::dp_cmd_t            cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LOAD  = 6'b000010,
		ST_QREAD = 6'b000100,
		ST_QCHK  = 6'b001000,
		ST_SCAN  = 6'b010000,
		ST_FINAL = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.capture    = accept;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (command == gbp_pkg::CMD_CLEAR) begin
						cmd.clear = 1'b1;
					end else if (command == gbp_pkg::CMD_LOAD) begin
						state_d = ST_LOAD;
					end else if (command == gbp_pkg::CMD_QUERY) begin
						state_d = ST_QREAD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_LOAD: begin
				cmd.load_wr = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_QREAD: begin
				cmd.q_read = 1'b1;
				state_d    = ST_QCHK;
			end
			ST_QCHK: begin
				cmd.q_check = 1'b1;
				state_d     = stat.q_ok ? ST_SCAN : ST_FINAL;
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_done) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				cmd.emit_final = 1'b1;
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/gbp_dp.sv =====
// ----------------------------------------------------------------------------
// gbp_dp: box store and pair search datapath
// Holds the box memory and fill count, the queried box, the scan counters,
// the compare stage, the pending pair and the output register.
// ----------------------------------------------------------------------------
module gbp_dp #(
	parameter int MAX_BULLETS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gbp_pkg::dp_cmd_t                    cmd,
	output gbp_pkg::dp_stat_t                   stat,
	input  logic signed [gbp_pkg::CoordW-1:0]   left_edge,
	input  logic signed [gbp_pkg::CoordW-1:0]   top_edge,
	input  logic signed [gbp_pkg::CoordW-1:0]   right_edge,
	input  logic signed [gbp_pkg::CoordW-1:0]   bottom_edge,
	input  logic                                is_live,
	input  logic [gbp_pkg::IdW-1:0]             owner_id,
	input  logic [gbp_pkg::IdW-1:0]             box_tag,
	input  logic [gbp_pkg::SlotW-1:0]           slot,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic [gbp_pkg::IdW-1:0]             first_tag,
	output logic [gbp_pkg::IdW-1:0]             second_tag,
	output logic                                last
);

	localparam int AddrW = $clog2(MAX_BULLETS);
	localparam int CntW  = $clog2(MAX_BULLETS + 1);
	localparam int CmpW  = (CntW > gbp_pkg::SlotW) ? CntW : gbp_pkg::SlotW;
	localparam int CellW = gbp_pkg::CellW;

	// Captured input word.
	gbp_pkg::box_entry_t          in_box_q;
	logic [gbp_pkg::SlotW-1:0]    slot_q;

	// Store.
	gbp_pkg::box_entry_t          mem [MAX_BULLETS];
	gbp_pkg::box_entry_t          rd_q;
	gbp_pkg::box_entry_t          wr_box;
	logic [CntW-1:0]              count_q;
	logic                         full;
	logic                         wr_en;
	logic                         rd_en;
	logic [AddrW-1:0]             rd_addr;

	// Scan.
	gbp_pkg::box_entry_t          me_q;
	logic [AddrW-1:0]             j_q;
	logic [1:0]                   dx_q, dy_q;
	logic [1:0]                   dx_s1, dy_s1;
	logic                         issued_q;
	logic                         s1_valid;
	logic                         issue;
	logic                         en;
	logic                         last_j;
	logic signed [2:0]            off_x, off_y;
	logic signed [CellW:0]        wx, wy;
	logic                         cand;
	logic                         hit_ok;

	// Pairs.
	logic                         pend_valid_q;
	logic [gbp_pkg::IdW-1:0]      pend_tag_q;
	logic [gbp_pkg::CountW-1:0]   pairs_q;
	logic                         mid_push;
	logic                         final_push;
	logic                         out_free;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_box_q.left   <= left_edge;
			in_box_q.right  <= right_edge;
			in_box_q.top    <= top_edge;
			in_box_q.bottom <= bottom_edge;
			in_box_q.live   <= is_live;
			in_box_q.owner  <= owner_id;
			in_box_q.tag    <= box_tag;
			in_box_q.cx     <= '0;
			in_box_q.cy     <= '0;
			slot_q          <= slot;
		end
	end

	always_comb begin
		wr_box    = in_box_q;
		wr_box.cx = gbp_pkg::cell_of(in_box_q.left);
		wr_box.cy = gbp_pkg::cell_of(in_box_q.top);
	end

	assign full  = (count_q == CntW'(MAX_BULLETS));
	assign wr_en = cmd.load_wr && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + CntW'(1);
		end
	end

	assign issue   = cmd.scan_run && !issued_q;
	assign rd_en   = cmd.q_read || (issue && en);
	assign rd_addr = cmd.q_read ? AddrW'(slot_q) : j_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AddrW'(count_q)] <= wr_box;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign stat.q_ok = (CmpW'(slot_q) < CmpW'(count_q)) && rd_q.live;

	// Compare stage: rd_q holds the most recently issued entry, read through the registered memory port.
	assign off_x = signed'({1'b0, dx_s1}) - 3'sd1;
	assign off_y = signed'({1'b0, dy_s1}) - 3'sd1;
	assign wx    = (CellW+1)'(me_q.cx) + (CellW+1)'(off_x);
	assign wy    = (CellW+1)'(me_q.cy) + (CellW+1)'(off_y);

	assign cand = ((CellW+1)'(rd_q.cx) == wx) && ((CellW+1)'(rd_q.cy) == wy)
		&& rd_q.live && (rd_q.tag > me_q.tag) && (rd_q.owner != me_q.owner)
		&& (me_q.right >= rd_q.left) && (me_q.left <= rd_q.right)
		&& (me_q.bottom >= rd_q.top) && (me_q.top <= rd_q.bottom);

	assign hit_ok   = s1_valid && cand && (pairs_q != gbp_pkg::RESULT_CAP);
	assign out_free = !out_valid || out_ready;
	assign en       = !(hit_ok && pend_valid_q && !out_free);
	assign mid_push = cmd.scan_run && hit_ok && pend_valid_q && out_free;
	assign final_push = cmd.emit_final && out_free;
	assign last_j   = (CntW'(j_q) == count_q - CntW'(1));

	assign stat.scan_done = issued_q && !s1_valid;
	assign stat.out_free  = out_free;

	always_ff @(posedge clk) begin
		if (cmd.q_check) begin
			me_q <= rd_q;
		end
		if (cmd.scan_run && en) begin
			dx_s1 <= dx_q;
			dy_s1 <= dy_q;
		end
		if (cmd.q_check) begin
			j_q  <= '0;
			dx_q <= '0;
			dy_q <= '0;
		end else if (issue && en) begin
			if (last_j) begin
				j_q <= '0;
				if (dy_q == 2'd2) begin
					dy_q <= '0;
					dx_q <= dx_q + 2'd1;
				end else begin
					dy_q <= dy_q + 2'd1;
				end
			end else begin
				j_q <= j_q + AddrW'(1);
			end
		end
		if (cmd.scan_run && en && hit_ok) begin
			pend_tag_q <= rd_q.tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issued_q     <= 1'b1;
			s1_valid     <= 1'b0;
			pend_valid_q <= 1'b0;
			pairs_q      <= '0;
		end else begin
			if (cmd.q_read) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.scan_run && en && hit_ok) begin
				pend_valid_q <= 1'b1;
			end
			if (cmd.q_check) begin
				issued_q <= 1'b0;
				s1_valid <= 1'b0;
				pairs_q  <= '0;
			end else if (cmd.scan_run && en) begin
				s1_valid <= issue;
				if (issue && last_j && dx_q == 2'd2 && dy_q == 2'd2) begin
					issued_q <= 1'b1;
				end
				if (hit_ok) begin
					pairs_q <= pairs_q + gbp_pkg::CountW'(1);
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (mid_push || final_push) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mid_push) begin
			hit        <= 1'b1;
			first_tag  <= me_q.tag;
			second_tag <= pend_tag_q;
			last       <= 1'b0;
		end else if (final_push) begin
			hit        <= pend_valid_q;
			first_tag  <= pend_valid_q ? me_q.tag : '0;
			second_tag <= pend_valid_q ? pend_tag_q : '0;
			last       <= 1'b1;
		end
	end

endmodule

// ===== design/grid_broad_phase_box_collision.sv =====
// ----------------------------------------------------------------------------
// grid_broad_phase_box_collision: uniform grid broad-phase box collision
// Stores boxes in load order and, for a queried box, reports up to 63 live
// boxes of another owner, higher tag and overlapping edges in its nine cells.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Word
//  -------  ---------------------  ----------------------------------------
//  in       in_valid / in_ready    command, left/top/right/bottom_edge,
//                                  is_live, owner_id, box_tag, slot
//  out      out_valid / out_ready  hit, first_tag, second_tag, last
//
// A query whose slot is empty or whose box is inactive skips the scan. The
// single read port of the box memory visits one stored entry per cycle in
// each of the nine cell passes, unless a stalled output holds the scan, so
// the search loop sets the rate. Reset empties the store at once; the box
// memory itself is never cleared. A stalled output holds the scan only when
// a second pair is found while the output word still waits, and holds the
// closing word.
//
// The controller takes one word at a time. Clear, load and the unused
// command code produce no result words; a query produces one word for each
// pair found (at most 63), with last set on the final one, or a single word
// with hit and last set to 0 and 1 when the box is inactive, the slot is
// empty, or nothing collides. Each pair found is held back in a pending
// register until the next pair or the end of the scan shows whether it is
// the final word, then moved into the output register. Grid cells are
// computed when a box is loaded, by a shift and a reciprocal multiply.
// ----------------------------------------------------------------------------
module grid_broad_phase_box_collision #(
	parameter int MAX_BULLETS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [gbp_pkg::CmdW-1:0]            command,
	input  logic signed [gbp_pkg::CoordW-1:0]   left_edge,
	input  logic signed [gbp_pkg::CoordW-1:0]   top_edge,
	input  logic signed [gbp_pkg::CoordW-1:0]   right_edge,
	input  logic signed [gbp_pkg::CoordW-1:0]   bottom_edge,
	input  logic                                is_live,
	input  logic [gbp_pkg::IdW-1:0]             owner_id,
	input  logic [gbp_pkg::IdW-1:0]             box_tag,
	input  logic [gbp_pkg::SlotW-1:0]           slot,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic [gbp_pkg::IdW-1:0]             first_tag,
	output logic [gbp_pkg::IdW-1:0]             second_tag,
	output logic                                last
);

	gbp_pkg::dp_cmd_t  dp_cmd;
	gbp_pkg::dp_stat_t dp_stat;

	// The sequencer decides what the datapath does each cycle.
	gbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	// The datapath owns the store, the scan and the output register.
	gbp_dp #(
		.MAX_BULLETS (MAX_BULLETS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.stat        (dp_stat),
		.left_edge   (left_edge),
		.top_edge    (top_edge),
		.right_edge  (right_edge),
		.bottom_edge (bottom_edge),
		.is_live     (is_live),
		.owner_id    (owner_id),
		.box_tag     (box_tag),
		.slot        (slot),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.first_tag   (first_tag),
		.second_tag  (second_tag),
		.last        (last)
	);

endmodule
